[rtl/amtd_pkg.sv]
// Shared sizes and types for the awareness matrix termination detector.
package amtd_pkg;

	// Matrix side and stored sequence width.
	localparam int MAX_AGENTS = 16;
	localparam int SEQ_W      = 32;

	// Index and address widths derived from the matrix side.
	localparam int IDX_W  = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int SIDE_W = $clog2(MAX_AGENTS + 1);
	localparam int ENTRY_W = SEQ_W + 1;

	// Port field widths.
	localparam int CNT_W     = 5;
	localparam int IN_SEQ_W  = 32;
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 8;
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_UPD   = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

[rtl/amtd_ram.sv]
// Generic simple dual-port RAM with registered read.
module amtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/awareness_matrix_termination_detector.sv]
// Awareness matrix termination detector: update one matrix entry, then scan for termination.
//
// Usage:
//   Input transactions on s_tvalid/s_tready/s_tdata carry one notification (sender,
//   subject, sequence, approved). Each one produces exactly one output transaction on
//   m_tvalid/m_tready/m_tdata with the finished flag and an index error flag.
//   cfg_we/cfg_wdata set the agent count; write only while the block is idle (unchecked).
// Timing:
//   The lower-triangle scan reads one matrix entry per cycle from the single read
//   port of the entry RAM. A new item is accepted only once the result of the last
//   one is in the output register and the block is back in idle.
// Reset:
//   arst_n clears the controller, the output register and one valid flag per
//   matrix entry, so the whole matrix reads as zero right after reset with no
//   clearing pass. The agent count returns to 16.
// Stall:
//   While m_tready is low the result is held; a finished scan waits for the
//   output register to free up before the block returns to idle.
module awareness_matrix_termination_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0: sender_index[4:0], subject_index[9:5], sequence_number[41:10],
	// approved_flag[42], zero fill [47:43].
	input  logic [amtd_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0: finished[0], index_error[1], zero fill [7:2].
	output logic [amtd_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_we,
	input  logic [amtd_pkg::CNT_W-1:0]       cfg_wdata
);

	localparam int IDX_W  = amtd_pkg::IDX_W;
	localparam int ADDR_W = amtd_pkg::ADDR_W;
	localparam int SEQ_W  = amtd_pkg::SEQ_W;
	localparam int SIDE_W = amtd_pkg::SIDE_W;
	localparam int CNT_W  = amtd_pkg::CNT_W;

	amtd_pkg::state_t state_q;

	logic [CNT_W-1:0]  count_q;
	logic [SIDE_W-1:0] side;
	logic [SIDE_W-1:0] side_q;
	logic [IDX_W-1:0]  last_q;

	logic [CNT_W-1:0]  in_snd;
	logic [CNT_W-1:0]  in_sub;
	logic [SEQ_W-1:0]  in_seq;
	logic              in_appr;
	logic              in_bad;
	logic              accept;

	logic [ADDR_W-1:0] upd_addr_q;
	logic [SEQ_W-1:0]  upd_seq_q;
	logic              upd_appr_q;
	logic              bad_q;

	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;

	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_raddr;
	logic [amtd_pkg::ENTRY_W-1:0] ram_wdata;
	logic [amtd_pkg::ENTRY_W-1:0] ram_rdata;

	logic [amtd_pkg::DEPTH-1:0] vld_q;
	logic                       vld_s1;
	logic [SEQ_W-1:0]           rd_seq;
	logic                       rd_appr;

	logic             chk_s1;
	logic             diag_s1;
	logic [SEQ_W-1:0] diag_q;
	logic             fail_q;
	logic             do_write;

	logic m_tvalid_q;
	logic fin_q;
	logic ierr_q;

	// Input field unpacking and range check against the effective count.
	assign in_snd  = s_tdata[4:0];
	assign in_sub  = s_tdata[9:5];
	assign in_seq  = SEQ_W'(s_tdata[41:10]);
	assign in_appr = s_tdata[42];
	assign side    = (count_q > CNT_W'(amtd_pkg::MAX_AGENTS)) ?
			SIDE_W'(amtd_pkg::MAX_AGENTS) : SIDE_W'(count_q);
	assign in_bad  = (in_snd == '0) || (in_sub == '0) ||
			(in_snd > CNT_W'(side)) || (in_sub > CNT_W'(side));

	assign s_tready = (state_q == amtd_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Agent count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= amtd_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Entry RAM: sequence in the low bits, approved mark on top.
	assign ram_raddr = (state_q == amtd_pkg::ST_IDLE) ?
			{IDX_W'(in_snd - CNT_W'(1)), IDX_W'(in_sub - CNT_W'(1))} : {row_q, col_q};
	assign ram_wdata = {upd_appr_q, upd_seq_q};
	assign ram_we    = (state_q == amtd_pkg::ST_UPD) && do_write;

	amtd_ram #(
		.WIDTH(amtd_pkg::ENTRY_W),
		.DEPTH(amtd_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(upd_addr_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// An entry never written reads as zero.
	assign rd_seq  = vld_s1 ? ram_rdata[SEQ_W-1:0] : '0;
	assign rd_appr = vld_s1 && ram_rdata[SEQ_W];

	// An item with valid indices overwrites on a newer sequence, or on an equal one not yet approved.
	assign do_write = !bad_q && ((rd_seq < upd_seq_q) || ((rd_seq == upd_seq_q) && !rd_appr));

	// Valid flags, written alongside the RAM and read with the same latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_q[ram_raddr];
			if (ram_we) begin
				vld_q[upd_addr_q] <= 1'b1;
			end
		end
	end

	// Item registers captured on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			upd_addr_q <= ram_raddr;
			upd_seq_q  <= in_seq;
			upd_appr_q <= in_appr;
			side_q     <= side;
			last_q     <= IDX_W'(side - SIDE_W'(1));
		end
	end

	// Scan check stage: the first entry of each column is its diagonal.
	always_ff @(posedge clk) begin
		if (state_q == amtd_pkg::ST_UPD) begin
			fail_q <= 1'b0;
		end else if (chk_s1) begin
			if (diag_s1) begin
				diag_q <= rd_seq;
				if ((rd_seq == '0) || !rd_appr) begin
					fail_q <= 1'b1;
				end
			end else if (!rd_appr || ((rd_seq != '0) && (rd_seq != diag_q))) begin
				fail_q <= 1'b1;
			end
		end
	end

	// Controller: update, lower-triangle walk, result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= amtd_pkg::ST_IDLE;
			bad_q      <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			chk_s1     <= 1'b0;
			diag_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
			fin_q      <= 1'b0;
			ierr_q     <= 1'b0;
		end else begin
			chk_s1  <= 1'b0;
			diag_s1 <= 1'b0;
			// The done state reloads the output register itself.
			if (m_tvalid_q && m_tready && (state_q != amtd_pkg::ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				amtd_pkg::ST_IDLE: begin
					if (accept) begin
						bad_q   <= in_bad;
						state_q <= amtd_pkg::ST_UPD;
					end
				end
				amtd_pkg::ST_UPD: begin
					row_q <= '0;
					col_q <= '0;
					if (side_q == '0) begin
						state_q <= amtd_pkg::ST_DONE;
					end else begin
						state_q <= amtd_pkg::ST_SCAN;
					end
				end
				amtd_pkg::ST_SCAN: begin
					chk_s1  <= 1'b1;
					diag_s1 <= (row_q == col_q);
					if (row_q == last_q) begin
						if (col_q == last_q) begin
							state_q <= amtd_pkg::ST_DRAIN;
						end else begin
							col_q <= col_q + IDX_W'(1);
							row_q <= col_q + IDX_W'(1);
						end
					end else begin
						row_q <= row_q + IDX_W'(1);
					end
				end
				amtd_pkg::ST_DRAIN: begin
					state_q <= amtd_pkg::ST_DONE;
				end
				amtd_pkg::ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						fin_q      <= !fail_q;
						ierr_q     <= bad_q;
						state_q    <= amtd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= amtd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output transaction.
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, ierr_q, fin_q};

endmodule

[rtl/amtd_checker.sv]
// Port-level checker for the awareness matrix termination detector, bound to the top level.
module amtd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [amtd_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The fill bits of the result are always zero.
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:2] == 6'b0))
		else $error("result fill bits not zero");

	// Items are processed one at a time: the input closes after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	// A new result never appears right after an acceptance.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid)))
		else $error("result appeared too early");

endmodule

bind awareness_matrix_termination_detector amtd_checker u_amtd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
